[rtl/core/dmc_pkg.sv]
// Shared types, constants and register map for the delta crusher.
package dmc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int PHASE_W    = 22;
    localparam int PHASE_FRAC = 16;
    localparam int SUM_W      = 26;
    localparam int LEVEL_W    = 7;
    localparam int SIL_W      = 10;
    localparam int HIST_TAPS  = 4;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 18;

    // Shared divider widths
    localparam int DIV_N_W = 38;
    localparam int DIV_D_W = 22;

    // Register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_BYPASS      = 3'd0;
    localparam logic [2:0] REG_INPUT_GAIN  = 3'd1;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd2;
    localparam logic [2:0] REG_RATE_PERIOD = 3'd3;
    localparam logic [2:0] REG_SILENCE_LIM = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_RESET    = 16'd16384;
    localparam logic [PHASE_W-1:0] PERIOD_RESET  = 22'd87202;
    localparam logic [SIL_W-1:0]   SILENCE_RESET = 10'd662;

    // Level limits
    localparam logic signed [LEVEL_W-1:0] LEVEL_HI = 7'sd62;
    localparam logic signed [LEVEL_W-1:0] LEVEL_LO = -7'sd62;
    localparam logic signed [LEVEL_W-1:0] LEVEL_STEP = 7'sd2;
    localparam int QUIET_MAX = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_IN,
        S_ACC,
        S_CHK,
        S_TDIV,
        S_FGO,
        S_FDIV,
        S_M1,
        S_A1,
        S_M2,
        S_A2,
        S_M3,
        S_A3,
        S_M4,
        S_OUT
    } t_state;

endpackage

[rtl/core/dmc_mul.sv]
// Registered signed multiplier shared by all products of the crusher.
module dmc_mul #(
    parameter int A_W = dmc_pkg::MUL_A_W,
    parameter int B_W = dmc_pkg::MUL_B_W
) (
    input  logic                      i_clk,
    input  logic signed [A_W-1:0]     i_a,
    input  logic signed [B_W-1:0]     i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/dmc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module dmc_div #(
    parameter int N_W = dmc_pkg::DIV_N_W,
    parameter int D_W = dmc_pkg::DIV_D_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W-1:0]   r_rem;
    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_div;

    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;
    logic [D_W-1:0]   n_rem;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_quo[N_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[N_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/core/dmc_delta_crusher.sv]
// Delta-modulation bit crusher: sequencer, state, config port and checks.
//
// Usage: one signed Q1.15 sample enters on i_valid/o_ready and one crushed
// sample leaves on o_valid/i_ready for every request. The user is to write
// settings over the APB-style port (psel/penable/pwrite/paddr/pwdata) only
// while idle; the block itself does not enforce this. Reads return the
// register values, pready is tied high. In bypass the sample appears in the
// cycle after acceptance. Otherwise o_valid rises once the sequencer reaches
// its output state; each pass of the shared restoring divider (interpolation
// fraction on every request, average too where the modulator steps) holds
// the sequencer, and each product waits on the registered shared multiplier.
// One request is in work at a time; o_ready is low from acceptance until the
// result has been taken, so no new request is taken before it has left.
// Reset clears the sum, phase, level, silence count and history and loads
// the default gains, period and silence limit.
// A stalled receiver holds o_valid and o_sample_out, and no new request is
// taken until the result leaves.
module dmc_delta_crusher #(
    parameter int DIV_N_W = dmc_pkg::DIV_N_W,
    parameter int DIV_D_W = dmc_pkg::DIV_D_W,
    parameter int MUL_A_W = dmc_pkg::MUL_A_W,
    parameter int MUL_B_W = dmc_pkg::MUL_B_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dmc_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [dmc_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmc_pkg::ADDR_W-1:0]          paddr,
    input  logic [dmc_pkg::DATA_W-1:0]          pwdata,
    output logic [dmc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int SW  = dmc_pkg::SAMPLE_W;
    localparam int GW  = dmc_pkg::GAIN_W;
    localparam int PW  = dmc_pkg::PHASE_W;
    localparam int PF  = dmc_pkg::PHASE_FRAC;
    localparam int UW  = dmc_pkg::SUM_W;
    localparam int LW  = dmc_pkg::LEVEL_W;
    localparam int CW  = dmc_pkg::SIL_W;
    localparam int PRW = MUL_A_W + MUL_B_W;
    localparam int TW  = DIV_N_W + 1;
    localparam int FW  = PF + 1;

    // Configuration registers
    logic          r_bypass;
    logic [GW-1:0] r_in_gain;
    logic [GW-1:0] r_out_gain;
    logic [PW-1:0] r_period_cfg;
    logic [CW-1:0] r_sil_limit;

    // Processing state
    dmc_pkg::t_state       r_state, n_state;
    logic signed [SW-1:0]  r_sample;
    logic signed [UW-1:0]  r_sum;
    logic [PW-1:0]         r_phase;
    logic signed [LW-1:0]  r_level;
    logic [CW-1:0]         r_sil_cnt;
    logic signed [SW-1:0]  r_hist [dmc_pkg::HIST_TAPS];
    logic                  r_neg;
    logic [FW-1:0]         r_frac;
    logic signed [MUL_A_W-1:0] r_y;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out;

    // Shared unit hookups
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PRW-1:0]     mul_p;
    logic                      div_start;
    logic [DIV_N_W-1:0]        div_n;
    logic [DIV_D_W-1:0]        div_d;
    logic                      div_done;
    logic [DIV_N_W-1:0]        div_q;

    logic                      accept;
    logic                      cfg_wr;
    logic [2:0]                cfg_idx;
    logic [PW-1:0]             period;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == dmc_pkg::S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_sample_out = r_out;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // Clamp the period to at least one host sample
    assign period = (r_period_cfg < PW'(1 << PF)) ? PW'(1 << PF) : r_period_cfg;

    // Config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass     <= 1'b0;
            r_in_gain    <= dmc_pkg::GAIN_RESET;
            r_out_gain   <= dmc_pkg::GAIN_RESET;
            r_period_cfg <= dmc_pkg::PERIOD_RESET;
            r_sil_limit  <= dmc_pkg::SILENCE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dmc_pkg::REG_BYPASS:      r_bypass     <= pwdata[0];
                dmc_pkg::REG_INPUT_GAIN:  r_in_gain    <= pwdata[GW-1:0];
                dmc_pkg::REG_OUTPUT_GAIN: r_out_gain   <= pwdata[GW-1:0];
                dmc_pkg::REG_RATE_PERIOD: r_period_cfg <= pwdata[PW-1:0];
                dmc_pkg::REG_SILENCE_LIM: r_sil_limit  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Config read
    always_comb begin
        case (cfg_idx)
            dmc_pkg::REG_BYPASS:      prdata = {31'd0, r_bypass};
            dmc_pkg::REG_INPUT_GAIN:  prdata = {16'd0, r_in_gain};
            dmc_pkg::REG_OUTPUT_GAIN: prdata = {16'd0, r_out_gain};
            dmc_pkg::REG_RATE_PERIOD: prdata = {10'd0, r_period_cfg};
            dmc_pkg::REG_SILENCE_LIM: prdata = {22'd0, r_sil_limit};
            default:                  prdata = '0;
        endcase
    end

    dmc_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    dmc_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmc_pkg::S_IDLE:   if (accept && !r_bypass) n_state = dmc_pkg::S_MUL_IN;
            dmc_pkg::S_MUL_IN: n_state = dmc_pkg::S_ACC;
            dmc_pkg::S_ACC:    n_state = dmc_pkg::S_CHK;
            dmc_pkg::S_CHK:    n_state = (r_phase >= period) ? dmc_pkg::S_TDIV
                                                             : dmc_pkg::S_FGO;
            dmc_pkg::S_TDIV:   if (div_done) n_state = dmc_pkg::S_FGO;
            dmc_pkg::S_FGO:    n_state = dmc_pkg::S_FDIV;
            dmc_pkg::S_FDIV:   if (div_done) n_state = dmc_pkg::S_M1;
            dmc_pkg::S_M1:     n_state = dmc_pkg::S_A1;
            dmc_pkg::S_A1:     n_state = dmc_pkg::S_M2;
            dmc_pkg::S_M2:     n_state = dmc_pkg::S_A2;
            dmc_pkg::S_A2:     n_state = dmc_pkg::S_M3;
            dmc_pkg::S_M3:     n_state = dmc_pkg::S_A3;
            dmc_pkg::S_A3:     n_state = dmc_pkg::S_M4;
            dmc_pkg::S_M4:     n_state = dmc_pkg::S_OUT;
            dmc_pkg::S_OUT:    n_state = dmc_pkg::S_IDLE;
            default:           n_state = dmc_pkg::S_IDLE;
        endcase
    end

    // Shared unit operands
    always_comb begin
        mul_a     = r_y;
        mul_b     = MUL_B_W'($signed({1'b0, r_frac}));
        div_start = 1'b0;
        div_n     = {r_phase, PF'(0)};
        div_d     = period;
        case (r_state)
            dmc_pkg::S_MUL_IN: begin
                mul_a = MUL_A_W'(r_sample);
                mul_b = MUL_B_W'($signed({1'b0, r_in_gain}));
            end
            dmc_pkg::S_M4: begin
                mul_b = MUL_B_W'($signed({1'b0, r_out_gain}));
            end
            dmc_pkg::S_CHK: begin
                div_start = (r_phase >= period);
                div_n     = DIV_N_W'({r_sum[UW-1] ? -r_sum : r_sum, 7'd0});
                div_d     = r_phase;
            end
            dmc_pkg::S_FGO: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    // Accumulate step values
    logic signed [UW+1:0]   scaled, sum_ext;
    logic signed [UW-1:0]   sum_sat;
    logic [PW:0]            phase_inc;
    always_comb begin
        scaled    = mul_p[dmc_pkg::GAIN_FRAC+UW+1:dmc_pkg::GAIN_FRAC];
        sum_ext   = (UW+2)'(r_sum) + scaled;
        if (sum_ext > (UW+2)'((1 << (UW - 1)) - 1))
            sum_sat = {1'b0, {(UW-1){1'b1}}};
        else if (sum_ext < -(UW+2)'(1 << (UW - 1)))
            sum_sat = {1'b1, {(UW-1){1'b0}}};
        else
            sum_sat = sum_ext[UW-1:0];
        phase_inc = {1'b0, r_phase} + (PW+1)'(1 << PF);
    end

    // Modulator step values
    logic signed [TW-1:0] target, lvl_ext;
    logic signed [LW-1:0] lvl_mv, lvl_new;
    logic [CW-1:0]        sil_new;
    always_comb begin
        target  = r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        lvl_ext = TW'(r_level);
        lvl_mv  = r_level;
        if (lvl_ext < target) begin
            if (r_level < dmc_pkg::LEVEL_HI) lvl_mv = r_level + dmc_pkg::LEVEL_STEP;
        end else begin
            if (r_level >= dmc_pkg::LEVEL_LO) lvl_mv = r_level - dmc_pkg::LEVEL_STEP;
        end
        lvl_new = lvl_mv;
        sil_new = r_sil_cnt;
        if (target < -TW'(dmc_pkg::QUIET_MAX) || target > TW'(dmc_pkg::QUIET_MAX))
            sil_new = '0;
        else if (r_sil_cnt < r_sil_limit)
            sil_new = r_sil_cnt + 1'b1;
        else
            lvl_new = '0;
    end

    // Hermite coefficients, doubled so the halves stay exact
    logic signed [MUL_A_W-1:0] xm1, x0, x1, x2, hc, hv, hw, ha, hb, hi;
    logic signed [MUL_A_W-1:0] y_end;
    logic signed [PRW-GW+1:0]  out_full;
    logic signed [SW-1:0]      out_sat;
    always_comb begin
        xm1 = MUL_A_W'(r_hist[0]);
        x0  = MUL_A_W'(r_hist[1]);
        x1  = MUL_A_W'(r_hist[2]);
        x2  = MUL_A_W'(r_hist[3]);
        hc  = x1 - xm1;
        hv  = (x0 - x1) <<< 1;
        hw  = hc + hv;
        ha  = hw + hv + (x2 - x0);
        hb  = hw + ha;
        hi  = mul_p[PF+MUL_A_W-1:PF];
        y_end = hi + (x0 <<< 1);
        out_full = mul_p[PRW-1:dmc_pkg::GAIN_FRAC];
        if (out_full > (PRW-GW+2)'((1 << (SW - 1)) - 1))
            out_sat = {1'b0, {(SW-1){1'b1}}};
        else if (out_full < -(PRW-GW+2)'(1 << (SW - 1)))
            out_sat = {1'b1, {(SW-1){1'b0}}};
        else
            out_sat = out_full[SW-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_phase     <= '0;
            r_level     <= '0;
            r_sil_cnt   <= '0;
            for (int k = 0; k < dmc_pkg::HIST_TAPS; k++) r_hist[k] <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                dmc_pkg::S_IDLE: if (accept && r_bypass) r_out_valid <= 1'b1;
                dmc_pkg::S_ACC: begin
                    r_sum   <= sum_sat;
                    r_phase <= phase_inc[PW] ? {PW{1'b1}} : phase_inc[PW-1:0];
                end
                dmc_pkg::S_TDIV: if (div_done) begin
                    r_sum     <= '0;
                    r_phase   <= r_phase - period;
                    r_level   <= lvl_new;
                    r_sil_cnt <= sil_new;
                    for (int k = dmc_pkg::HIST_TAPS - 1; k > 0; k--)
                        r_hist[k] <= r_hist[k-1];
                    r_hist[0] <= {lvl_new, (SW-LW)'(0)};
                end
                dmc_pkg::S_OUT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            dmc_pkg::S_IDLE: if (accept) begin
                r_sample <= i_sample_in;
                r_out    <= i_sample_in;
            end
            dmc_pkg::S_CHK:  r_neg <= r_sum[UW-1];
            dmc_pkg::S_FDIV: if (div_done) begin
                r_frac <= (div_q > DIV_N_W'(1 << PF)) ? FW'(1 << PF) : div_q[FW-1:0];
                r_y    <= ha;
            end
            dmc_pkg::S_A1:   r_y <= hi - hb;
            dmc_pkg::S_A2:   r_y <= hi + hc;
            dmc_pkg::S_A3:   r_y <= y_end >>> 1;
            dmc_pkg::S_OUT:  r_out <= out_sat;
            default: ;
        endcase
    end

    // Checks
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while a result is pending");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready) else $error("ready right after accepting a request");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == dmc_pkg::S_TDIV || r_state == dmc_pkg::S_FDIV))
        else $error("divider finished outside a wait state");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == dmc_pkg::S_OUT || $past(r_bypass)))
        else $error("result raised without a finished request");

endmodule

[tb/dmc_checker.sv]
// Checker for the delta crusher: watches the ports, predicts each result and compares.
module dmc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_ready,
    input  logic signed [dmc_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic signed [dmc_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [dmc_pkg::ADDR_W-1:0]          paddr,
    input  logic [dmc_pkg::DATA_W-1:0]          pwdata,
    output int                                  o_fails,
    output int                                  o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = dmc_pkg::SAMPLE_W;
    localparam longint ONE_PHASE = 64'sd1 << dmc_pkg::PHASE_FRAC;
    localparam longint PHASE_TOP = (64'sd1 << dmc_pkg::PHASE_W) - 1;
    localparam longint SUM_TOP   = (64'sd1 << (dmc_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_BOT   = -(64'sd1 << (dmc_pkg::SUM_W - 1));

    // shadow of the register file
    longint cfg_bypass, cfg_gain_in, cfg_gain_out, cfg_period, cfg_quiet_lim;
    // shadow of the modulator state
    longint acc_sum, mod_phase, dm_level, quiet_cnt;
    longint level_hist [dmc_pkg::HIST_TAPS];

    logic signed [SW-1:0] crushed_q [$];
    int fails;

    assign o_fails   = fails;
    assign o_waiting = crushed_q.size();

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Hermite over the history, values kept at twice Q1.15 so halves stay exact
    function automatic longint interp(longint f, longint xm1, longint x0, longint x1,
                                      longint x2);
        longint c, v, w, a, b, y;
        c = x1 - xm1;
        v = 2 * (x0 - x1);
        w = c + v;
        a = w + v + (x2 - x0);
        b = w + a;
        y = fdiv(a * f, ONE_PHASE) - b;
        y = fdiv(y * f, ONE_PHASE) + c;
        y = fdiv(y * f, ONE_PHASE) + 2 * x0;
        return fdiv(y, 2);
    endfunction

    // advance the modulator by one sample and return the crushed output
    function automatic logic signed [SW-1:0] crush(logic signed [SW-1:0] smp);
        longint per, target, frac, y;
        if (cfg_bypass != 0) return smp;
        acc_sum = clip(acc_sum + fdiv(longint'(smp) * cfg_gain_in,
                                      64'sd1 << dmc_pkg::GAIN_FRAC),
                       SUM_BOT, SUM_TOP);
        mod_phase = clip(mod_phase + ONE_PHASE, 0, PHASE_TOP);
        per = (cfg_period < ONE_PHASE) ? ONE_PHASE : cfg_period;
        if (mod_phase >= per) begin
            target = (acc_sum * 64 * ONE_PHASE) / (mod_phase * (64'sd1 << (SW - 1)));
            mod_phase -= per;
            acc_sum = 0;
            if (dm_level < target) begin
                if (dm_level < dmc_pkg::LEVEL_HI) dm_level += dmc_pkg::LEVEL_STEP;
            end else begin
                if (dm_level >= dmc_pkg::LEVEL_LO) dm_level -= dmc_pkg::LEVEL_STEP;
            end
            if (target < -dmc_pkg::QUIET_MAX || target > dmc_pkg::QUIET_MAX) begin
                quiet_cnt = 0;
            end else if (quiet_cnt < cfg_quiet_lim) begin
                quiet_cnt++;
            end else begin
                dm_level = 0;
            end
            for (int i = dmc_pkg::HIST_TAPS - 1; i > 0; i--) level_hist[i] = level_hist[i-1];
            level_hist[0] = dm_level * (64'sd1 << (SW - dmc_pkg::LEVEL_W));
        end
        frac = (mod_phase * ONE_PHASE) / per;
        if (frac > ONE_PHASE) frac = ONE_PHASE;
        y = interp(frac, level_hist[0], level_hist[1], level_hist[2], level_hist[3]);
        y = fdiv(y * cfg_gain_out, 64'sd1 << dmc_pkg::GAIN_FRAC);
        y = clip(y, -(64'sd1 << (SW - 1)), (64'sd1 << (SW - 1)) - 1);
        return y[SW-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [SW-1:0] want;
        if (!i_rst_n) begin
            cfg_bypass    <= 0;
            cfg_gain_in   <= dmc_pkg::GAIN_RESET;
            cfg_gain_out  <= dmc_pkg::GAIN_RESET;
            cfg_period    <= dmc_pkg::PERIOD_RESET;
            cfg_quiet_lim <= dmc_pkg::SILENCE_RESET;
            acc_sum   = 0;
            mod_phase = 0;
            dm_level  = 0;
            quiet_cnt = 0;
            foreach (level_hist[i]) level_hist[i] = 0;
            crushed_q.delete();
            fails = 0;
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[dmc_pkg::ADDR_W-1:2])
                    dmc_pkg::REG_BYPASS:      cfg_bypass    <= pwdata[0];
                    dmc_pkg::REG_INPUT_GAIN:  cfg_gain_in   <= pwdata[dmc_pkg::GAIN_W-1:0];
                    dmc_pkg::REG_OUTPUT_GAIN: cfg_gain_out  <= pwdata[dmc_pkg::GAIN_W-1:0];
                    dmc_pkg::REG_RATE_PERIOD: cfg_period    <= pwdata[dmc_pkg::PHASE_W-1:0];
                    dmc_pkg::REG_SILENCE_LIM: cfg_quiet_lim <= pwdata[dmc_pkg::SIL_W-1:0];
                    default: ;
                endcase
            end
            // predict on each accepted request
            if (i_valid && o_ready) crushed_q.push_back(crush(i_sample_in));
            // compare each accepted result
            if (o_valid && i_ready) begin
                if (crushed_q.size() == 0) begin
                    $error("sample_out: unexpected result %0d", o_sample_out);
                    fails++;
                end else begin
                    want = crushed_q.pop_front();
                    if (want !== o_sample_out) begin
                        $error("sample_out expected %0d actual %0d", want, o_sample_out);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_dmc_delta_crusher.sv]
// Testbench top for the delta crusher: stimulus, register setup and verdict.
module tb_dmc_delta_crusher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = dmc_pkg::SAMPLE_W;
    localparam int DW = dmc_pkg::DATA_W;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 120;

    typedef enum int {MODE_NOISE, MODE_HOLD, MODE_QUIET, MODE_RAMP, MODE_SQUARE} t_mode;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic signed [SW-1:0]             i_sample_in = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic signed [SW-1:0]             o_sample_out;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [dmc_pkg::ADDR_W-1:0]       paddr = '0;
    logic [DW-1:0]                    pwdata = '0;
    logic [DW-1:0]                    prdata;
    logic                             pready;

    int  fails, waiting;
    int  n_sent = 0;
    int  n_done = 0;
    int  stall = 0;
    bit  calm = 1'b0;

    always #5 i_clk = ~i_clk;

    dmc_delta_crusher DUT (.*);

    dmc_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_sample_in, .o_valid, .i_ready,
        .o_sample_out, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fails(fails), .o_waiting(waiting)
    );

    // receiver: stall in random bursts, none in the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall   <= 0;
        end else if (stall > 0) begin
            stall <= stall - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            stall   <= $urandom_range(1, 12);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // count results taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) n_done <= n_done + 1;
    end

    // present one request and hold it until accepted
    task automatic send(logic signed [SW-1:0] smp);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain outstanding results, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        wait (n_done == n_sent);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 1638;
            1:       return 32768;
            2:       return $urandom_range(0, 65535);
            default: return $urandom_range(1638, 32768);
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_period();
        case ($urandom_range(0, 6))
            0:       return $urandom_range(0, 65535);
            1:       return 65536;
            2:       return 4194303;
            3:       return $urandom_range(65536, 400000);
            default: return $urandom_range(65536, 200000);
        endcase
    endfunction

    initial begin
        t_mode mode;
        int    amp, base, step_sz;
        logic signed [SW-1:0] smp;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset settings, then bypass
        send(16'sh7FFF); send(16'sh7FFF); send(16'sh7FFF); send(-16'sh8000);
        send(-16'sh8000); send(16'sh0000); send(16'sh0001); send(-16'sh0001);
        send(16'sh5555); send(16'shAAAA);
        drain();
        reg_write(dmc_pkg::REG_BYPASS, 1);
        send(16'sh7FFF); send(-16'sh8000); send(16'sh1234);
        drain();
        // period below one, input and output gains of 32768, unused register write
        reg_write(dmc_pkg::REG_BYPASS, 0);
        reg_write(dmc_pkg::REG_RATE_PERIOD, 0);
        reg_write(dmc_pkg::REG_OUTPUT_GAIN, 32768);
        reg_write(dmc_pkg::REG_INPUT_GAIN, 32768);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (8) send(16'sh7FFF);
        repeat (4) send(-16'sh8000);
        drain();

        // random phases, each with its own settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) calm = 1'b1;
            reg_write(dmc_pkg::REG_BYPASS, DW'($urandom_range(0, 5) == 0));
            reg_write(dmc_pkg::REG_INPUT_GAIN, pick_gain());
            reg_write(dmc_pkg::REG_OUTPUT_GAIN, pick_gain());
            reg_write(dmc_pkg::REG_RATE_PERIOD, pick_period());
            case ($urandom_range(0, 3))
                0:       reg_write(dmc_pkg::REG_SILENCE_LIM, 0);
                1:       reg_write(dmc_pkg::REG_SILENCE_LIM, 1023);
                2:       reg_write(dmc_pkg::REG_SILENCE_LIM, $urandom_range(1, 1023));
                default: reg_write(dmc_pkg::REG_SILENCE_LIM, $urandom_range(0, 6));
            endcase
            if ($urandom_range(0, 3) == 0) reg_write(3'($urandom_range(5, 7)), $urandom());
            amp  = $urandom_range(0, 32767);
            base = 0;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // switch stream shape now and then; most items follow a shape
                if (k % 30 == 0) begin
                    mode    = t_mode'($urandom_range(0, 4));
                    amp     = $urandom_range(0, 32767);
                    step_sz = $urandom_range(1, 4000);
                end
                if ($urandom_range(0, 4) == 0) begin
                    smp = SW'($urandom());
                end else begin
                    case (mode)
                        MODE_HOLD:   smp = SW'(($urandom_range(0, 1)) ? amp : -amp);
                        MODE_QUIET:  smp = SW'($signed($urandom_range(0, 400)) - 200);
                        MODE_RAMP: begin
                            base = base + step_sz;
                            if (base > 32767) base = -32768;
                            smp = SW'(base);
                        end
                        MODE_SQUARE: smp = SW'(((k / 8) % 2) ? amp : -amp - 1);
                        default:     smp = SW'($urandom());
                    endcase
                end
                send(smp);
            end
            drain();
        end

        if (fails == 0 && waiting == 0) begin
            $display("dmc_delta_crusher: match");
        end else begin
            $display("dmc_delta_crusher: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("dmc_delta_crusher: mismatch");
        $finish;
    end
endmodule

[sim.f]
rtl/core/dmc_pkg.sv
rtl/core/dmc_mul.sv
rtl/core/dmc_div.sv
rtl/core/dmc_delta_crusher.sv
tb/dmc_checker.sv
tb/tb_dmc_delta_crusher.sv
